// File: sv/previous_greater_element_top_assert.svh
// Assertion macros for the previous greater element block.
`ifndef PREVIOUS_GREATER_ELEMENT_TOP_ASSERT_SVH
`define PREVIOUS_GREATER_ELEMENT_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define PGE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PGE_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PGE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PGE_ASSERT(label, prop, msg)
`define PGE_ASSERT_IMPL(label, ante, cons, msg)
`define PGE_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// File: sv/pge_pkg.sv
`timescale 1ns / 1ps

package pge_pkg;

    localparam int VALUE_WIDTH = 32;

    typedef struct packed {
        logic                           start_req;
        logic signed [VALUE_WIDTH-1:0]  value;
    } pge_req_t;

    typedef struct packed {
        logic                           found;
        logic signed [VALUE_WIDTH-1:0]  greater_value;
        logic                           overflowed;
    } pge_rsp_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_WAIT,
        S_DONE
    } pge_state_t;

endpackage

// File: sv/previous_greater_element_top.sv
// An accepted request moves from S_IDLE to S_CHECK; with an empty stack it goes straight to
// S_DONE, else each compare in S_WAIT waits on a registered read of the stack memory and
// either pops and returns to S_CHECK or finds a greater entry and goes to S_DONE, which
// pushes the value and loads the output register; a new request waits until S_IDLE.
// A new request is taken while the previous response still waits in the output register.
// Reset (rst_n low, asynchronous) empties the stack and clears the overflow flag;
// the stack memory itself is not cleared.
`timescale 1ns / 1ps
`include "previous_greater_element_top_assert.svh"

module previous_greater_element_top #(
    parameter int DEPTH = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  pge_pkg::pge_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output pge_pkg::pge_rsp_t rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int VW = pge_pkg::VALUE_WIDTH;

    pge_pkg::pge_state_t state_reg, state_next;
    logic [AW-1:0]        top_reg, top_next;
    logic [CW-1:0]        count_reg, count_next;
    logic                 lost_reg, lost_next;
    logic signed [VW-1:0] value_reg, value_next;
    logic                 found_reg, found_next;
    logic signed [VW-1:0] greater_reg, greater_next;
    logic                 out_valid_reg, out_valid_next;
    pge_pkg::pge_rsp_t    out_data_reg, out_data_next;

    logic signed [VW-1:0] mem [DEPTH];
    logic signed [VW-1:0] rd_data_reg;
    logic [AW-1:0]        rd_addr;
    logic                 rd_en;
    logic                 wr_en;
    logic [AW-1:0]        below_top;
    logic [AW-1:0]        above_top;
    logic                 out_free;
    logic                 full;
    logic                 miss_rsp;
    logic                 start_fire;

    assign below_top = (top_reg == '0) ? AW'(DEPTH - 1) : top_reg - AW'(1);
    assign above_top = (top_reg == AW'(DEPTH - 1)) ? '0 : top_reg + AW'(1);
    assign out_free  = !out_valid_reg || !rsp_stall;
    assign full      = (count_reg == CW'(DEPTH));
    assign rd_addr   = below_top;

    assign req_stall = (state_reg != pge_pkg::S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_data_reg;

    assign miss_rsp   = rsp_valid && !rsp.found;
    assign start_fire = req_valid && !req_stall && req.start_req;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[top_reg] <= value_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pge_pkg::S_IDLE;
            top_reg       <= '0;
            count_reg     <= '0;
            lost_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            top_reg       <= top_next;
            count_reg     <= count_next;
            lost_reg      <= lost_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        found_reg    <= found_next;
        greater_reg  <= greater_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        top_next       = top_reg;
        count_next     = count_reg;
        lost_next      = lost_reg;
        value_next     = value_reg;
        found_next     = found_reg;
        greater_next   = greater_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        rd_en          = 1'b0;
        wr_en          = 1'b0;

        unique case (state_reg)
            pge_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    value_next = req.value;
                    if (req.start_req)
                    begin
                        top_next   = '0;
                        count_next = '0;
                        lost_next  = 1'b0;
                    end
                    state_next = pge_pkg::S_CHECK;
                end
            end
            pge_pkg::S_CHECK:
            begin
                if (count_reg == '0)
                begin
                    found_next   = 1'b0;
                    greater_next = '0;
                    state_next   = pge_pkg::S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = pge_pkg::S_WAIT;
                end
            end
            pge_pkg::S_WAIT:
            begin
                if (rd_data_reg <= value_reg)
                begin
                    // pop
                    top_next   = below_top;
                    count_next = count_reg - CW'(1);
                    state_next = pge_pkg::S_CHECK;
                end
                else
                begin
                    found_next   = 1'b1;
                    greater_next = rd_data_reg;
                    state_next   = pge_pkg::S_DONE;
                end
            end
            pge_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    // push and emit the transaction
                    wr_en    = 1'b1;
                    top_next = above_top;
                    if (full)
                    begin
                        lost_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    out_valid_next              = 1'b1;
                    out_data_next.found         = found_reg;
                    out_data_next.greater_value = greater_reg;
                    out_data_next.overflowed    = lost_reg || full;
                    state_next                  = pge_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pge_pkg::S_IDLE;
            end
        endcase
    end

    `PGE_ASSERT(a_count_bound, count_reg <= CW'(DEPTH), "entry count beyond depth")
    `PGE_ASSERT_IMPL(a_read_counted, state_reg == pge_pkg::S_WAIT, count_reg != '0, "empty read")
    `PGE_ASSERT_IMPL(a_lost_rise, $rose(lost_reg), $past(full), "overflow while not full")
    `PGE_ASSERT_IMPL(a_zero_greater, miss_rsp, rsp.greater_value == '0, "greater value not zero")
    `PGE_ASSERT_NEXT(a_start_clear, start_fire, count_reg == '0 && !lost_reg, "stack not cleared")

endmodule
